/* rtl/ppdb_pkg.sv */
`default_nettype none
package ppdb_pkg;

    // default store geometry
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 64;

    // signed width of projected cell positions
    localparam int POS_W = 26;

    localparam logic [7:0] GLYPH_SPACE = 8'd32;

    // register reset values
    localparam logic [7:0]  SCREEN_WIDTH_RST  = 8'd80;
    localparam logic [6:0]  SCREEN_HEIGHT_RST = 7'd40;
    localparam logic [30:0] EYE_DISTANCE_RST  = 31'd655360;
    localparam logic [30:0] SCREEN_OFFSET_RST = 31'd655360;

    // register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_EYE_DISTANCE  = 2'd2;
    localparam logic [1:0] CFG_SCREEN_OFFSET = 2'd3;

    // item functions; the unused selector is taken and dropped
    localparam logic [1:0] FUNC_PLOT  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // result status codes
    localparam logic [2:0] STATUS_DRAWN   = 3'd0;
    localparam logic [2:0] STATUS_HIDDEN  = 3'd1;
    localparam logic [2:0] STATUS_OFF     = 3'd2;
    localparam logic [2:0] STATUS_BEHIND  = 3'd3;
    localparam logic [2:0] STATUS_CLEARED = 3'd4;
    localparam logic [2:0] STATUS_READ    = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] x_coord;
        logic [31:0] y_coord;
        logic [31:0] z_coord;
        logic [7:0]  glyph;
        logic [6:0]  read_column;
        logic [5:0]  read_row;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  cell_column;
        logic [5:0]  cell_row;
        logic [7:0]  glyph_out;
        logic [31:0] depth_out;
    } out_t;

    // which result the output register takes
    typedef enum logic [2:0] {
        RES_BEHIND,
        RES_OFF,
        RES_PLOT,
        RES_CLEAR,
        RES_READ
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_init;
        logic     div_step;
        logic     mul_x;
        logic     mul_y;
        logic     rnd_y;
        logic     pos;
        logic     rd_plot;
        logic     rd_read;
        logic     plot_wb;
        logic     clr_wr;
        logic     out_load;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_func;
        logic       behind;
        logic       div_last;
        logic       off;
        logic       clr_last;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

/* rtl/ppdb_ram.sv */
`default_nettype none
module ppdb_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/ppdb_ctrl.sv */
`default_nettype none
module ppdb_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire ppdb_pkg::sts_t  sts,
    output ppdb_pkg::cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MULX,
        S_MULY,
        S_RNDY,
        S_POS,
        S_TEST,
        S_PWB,
        S_READ,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    ppdb_pkg::res_sel_t res_reg, res_next;
    logic               clr_item_reg, clr_item_next;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        clr_item_next = clr_item_reg;
        cmd           = '0;
        cmd.res_sel   = res_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    if (clr_item_reg) begin
                        res_next   = ppdb_pkg::RES_CLEAR;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (sts.in_func)
                        ppdb_pkg::FUNC_PLOT:  state_next = S_CHECK;
                        ppdb_pkg::FUNC_CLEAR: begin
                            clr_item_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        ppdb_pkg::FUNC_READ:  state_next = S_READ;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_CHECK: begin
                if (sts.behind) begin
                    res_next   = ppdb_pkg::RES_BEHIND;
                    state_next = S_OUT;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_MULX;
                end
            end
            S_MULX: begin
                cmd.mul_x  = 1'b1;
                state_next = S_MULY;
            end
            S_MULY: begin
                cmd.mul_y  = 1'b1;
                state_next = S_RNDY;
            end
            S_RNDY: begin
                cmd.rnd_y  = 1'b1;
                state_next = S_POS;
            end
            S_POS: begin
                cmd.pos    = 1'b1;
                state_next = S_TEST;
            end
            S_TEST: begin
                if (sts.off) begin
                    res_next   = ppdb_pkg::RES_OFF;
                    state_next = S_OUT;
                end else begin
                    cmd.rd_plot = 1'b1;
                    state_next  = S_PWB;
                end
            end
            S_PWB: begin
                cmd.plot_wb = 1'b1;
                res_next    = ppdb_pkg::RES_PLOT;
                state_next  = S_OUT;
            end
            S_READ: begin
                cmd.rd_read = 1'b1;
                res_next    = ppdb_pkg::RES_READ;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load  = 1'b1;
                    clr_item_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register; reset starts with a pass over the frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            res_reg      <= ppdb_pkg::RES_CLEAR;
            clr_item_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            res_reg      <= res_next;
            clr_item_reg <= clr_item_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule
`default_nettype wire

/* rtl/ppdb_dp.sv */
`default_nettype none
module ppdb_dp #(
    parameter int MAX_COLUMNS = ppdb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ppdb_pkg::MAX_ROWS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [1:0]     cfg_wr_index,
    input  wire logic [30:0]    cfg_wr_data,
    input  wire ppdb_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output ppdb_pkg::out_t      m_data,
    input  wire ppdb_pkg::cmd_t cmd,
    output ppdb_pkg::sts_t      sts
);

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = ppdb_pkg::POS_W;

    ppdb_pkg::in_t  in_reg;
    ppdb_pkg::out_t m_data_reg, res_w;
    logic           m_valid_reg;

    logic [7:0]  width_reg;
    logic [6:0]  height_reg;
    logic [30:0] eye_reg;
    logic [30:0] off_reg;

    logic [32:0] den_reg;
    logic        sat_reg;
    logic [32:0] rem_reg;
    logic [31:0] q_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] prod_reg;
    logic [23:0] rx_reg, ry_reg;
    logic [PW-1:0] col_reg, row_reg;
    logic [AW-1:0] clr_reg;

    logic [33:0] den_w;
    logic        sat_w;
    logic        nbit;
    logic [33:0] shift_w, diff_w;
    logic        ge_w;
    logic [31:0] factor_w;
    logic [31:0] magx, magy, mul_a;
    logic [63:0] rnd_w;
    logic [PW-1:0] wv, hv, offx, offy;
    logic [AW-1:0] plot_addr, read_addr, ram_addr;
    logic        ram_we, ram_re;
    logic [39:0] ram_wdata, ram_rdata;
    logic        hit, rd_in;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ppdb_pkg::SCREEN_WIDTH_RST;
            height_reg <= ppdb_pkg::SCREEN_HEIGHT_RST;
            eye_reg    <= ppdb_pkg::EYE_DISTANCE_RST;
            off_reg    <= ppdb_pkg::SCREEN_OFFSET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                ppdb_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_wr_data[7:0];
                ppdb_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_wr_data[6:0];
                ppdb_pkg::CFG_EYE_DISTANCE:  eye_reg    <= cfg_wr_data;
                ppdb_pkg::CFG_SCREEN_OFFSET: off_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // denominator, sign and saturation test (quotient >= 2^32 iff eye >= den*256)
    assign den_w = {{2{in_reg.z_coord[31]}}, in_reg.z_coord}
                 + {3'b000, eye_reg} + {3'b000, off_reg};
    assign sat_w = {11'b0, eye_reg} >= {den_w, 8'b0};

    // restoring divider step; dividend is eye << 24
    assign nbit    = (cnt_reg[4] & cnt_reg[3]) ? eye_reg[cnt_reg[2:0]] : 1'b0;
    assign shift_w = {rem_reg, nbit};
    assign diff_w  = shift_w - {1'b0, den_reg};
    assign ge_w    = shift_w >= {1'b0, den_reg};
    assign factor_w = sat_reg ? '1 : q_reg;

    // coordinate magnitudes for the shared multiplier
    assign magx  = in_reg.x_coord[31] ? (~in_reg.x_coord + 32'd1) : in_reg.x_coord;
    assign magy  = in_reg.y_coord[31] ? (~in_reg.y_coord + 32'd1) : in_reg.y_coord;
    assign mul_a = cmd.mul_y ? magy : magx;
    assign rnd_w = prod_reg + 64'h0000_0080_0000_0000;

    // area in use, clamped to the store
    assign wv = (PW'(width_reg) > PW'(MAX_COLUMNS)) ? PW'(MAX_COLUMNS) : PW'(width_reg);
    assign hv = (PW'(height_reg) > PW'(MAX_ROWS)) ? PW'(MAX_ROWS) : PW'(height_reg);
    assign offx = in_reg.x_coord[31] ? (PW'(0) - PW'(rx_reg)) : PW'(rx_reg);
    assign offy = in_reg.y_coord[31] ? (PW'(0) - PW'(ry_reg)) : PW'(ry_reg);

    // arithmetic registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_init) begin
            cnt_reg <= 5'd31;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.div_init) begin
            den_reg <= den_w[32:0];
            sat_reg <= sat_w;
            rem_reg <= {10'b0, eye_reg[30:8]};
            q_reg   <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= ge_w ? diff_w[32:0] : shift_w[32:0];
            q_reg   <= {q_reg[30:0], ge_w};
        end
        if (cmd.mul_x || cmd.mul_y) begin
            prod_reg <= mul_a * factor_w;
        end
        if (cmd.mul_y) begin
            rx_reg <= rnd_w[63:40];
        end
        if (cmd.rnd_y) begin
            ry_reg <= rnd_w[63:40];
        end
        if (cmd.pos) begin
            col_reg <= {1'b0, wv[PW-1:1]} + offx;
            row_reg <= {1'b0, hv[PW-1:1]} - offy;
        end
    end

    // clearing pass address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_reg <= sts.clr_last ? '0 : clr_reg + AW'(1);
        end
    end

    // frame store access
    assign plot_addr = AW'(row_reg) * AW'(MAX_COLUMNS) + AW'(col_reg);
    assign read_addr = AW'(in_reg.read_row) * AW'(MAX_COLUMNS) + AW'(in_reg.read_column);
    assign hit       = factor_w > ram_rdata[31:0];
    assign ram_we    = cmd.clr_wr | (cmd.plot_wb & hit);
    assign ram_re    = cmd.rd_plot | cmd.rd_read;
    assign ram_addr  = cmd.clr_wr ? clr_reg : (cmd.rd_read ? read_addr : plot_addr);
    assign ram_wdata = cmd.clr_wr ? {ppdb_pkg::GLYPH_SPACE, 32'd0}
                                  : {in_reg.glyph, factor_w};

    ppdb_ram #(
        .WIDTH(40),
        .DEPTH(CELLS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .re   (ram_re),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign rd_in = (32'(in_reg.read_column) < 32'(MAX_COLUMNS))
                && (32'(in_reg.read_row) < 32'(MAX_ROWS));

    // result formation
    always_comb begin
        res_w = '0;
        case (cmd.res_sel)
            ppdb_pkg::RES_BEHIND: res_w.status = ppdb_pkg::STATUS_BEHIND;
            ppdb_pkg::RES_OFF:    res_w.status = ppdb_pkg::STATUS_OFF;
            ppdb_pkg::RES_CLEAR:  res_w.status = ppdb_pkg::STATUS_CLEARED;
            ppdb_pkg::RES_PLOT: begin
                res_w.status      = hit ? ppdb_pkg::STATUS_DRAWN : ppdb_pkg::STATUS_HIDDEN;
                res_w.cell_column = col_reg[6:0];
                res_w.cell_row    = row_reg[5:0];
                res_w.glyph_out   = hit ? in_reg.glyph : ram_rdata[39:32];
                res_w.depth_out   = hit ? factor_w : ram_rdata[31:0];
            end
            ppdb_pkg::RES_READ: begin
                res_w.status      = ppdb_pkg::STATUS_READ;
                res_w.cell_column = in_reg.read_column;
                res_w.cell_row    = in_reg.read_row;
                res_w.glyph_out   = rd_in ? ram_rdata[39:32] : ppdb_pkg::GLYPH_SPACE;
                res_w.depth_out   = rd_in ? ram_rdata[31:0] : 32'd0;
            end
            default: res_w = '0;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= res_w;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // status to the controller
    assign sts.in_func  = s_data.func;
    assign sts.behind   = den_w[33] | (den_w == '0);
    assign sts.div_last = (cnt_reg == 5'd0);
    assign sts.off      = (col_reg >= wv) | (row_reg >= hv);
    assign sts.clr_last = (clr_reg == AW'(CELLS - 1));
    assign sts.out_free = ~m_valid_reg | m_ready;

endmodule
`default_nettype wire

/* rtl/point_projection_depth_buffer_top.sv */
`default_nettype none
// Perspective point plotter over a character frame with a per-cell depth buffer.
// One item is processed at a time; s_ready is high only while the block waits
// for an item. A plot runs a 32-step restoring divider for the depth factor
// (one quotient bit per cycle), one shared 32x32 multiplier used for x then y,
// a position/bounds step and a read-modify-write of the frame RAM. A clear
// writes one RAM entry per cycle. After reset the same clearing pass over all
// MAX_COLUMNS*MAX_ROWS cells (8192 at the defaults) runs before the first item
// is taken; configuration writes are taken at any time. Results sit in an
// output register, so the next item is taken while a result waits on m_ready.
module point_projection_depth_buffer_top #(
    parameter int MAX_COLUMNS = ppdb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ppdb_pkg::MAX_ROWS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [1:0]     cfg_wr_index,
    input  wire logic [30:0]    cfg_wr_data,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ppdb_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output ppdb_pkg::out_t      m_data
);

    ppdb_pkg::cmd_t cmd;
    ppdb_pkg::sts_t sts;

    ppdb_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    ppdb_dp #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
`default_nettype wire

/* rtl/ppdb_checker.sv */
`default_nettype none
module ppdb_assert (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire ppdb_pkg::in_t  s_data,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire ppdb_pkg::out_t m_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item at a time: ready drops after an input transfer other than FUNC_NONE
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.func != ppdb_pkg::FUNC_NONE) |=> !s_ready)
        else $error("ready stayed high after transfer");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ppdb_pkg::STATUS_READ)
        else $error("undefined status code");

    // results without a cell carry zero fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ppdb_pkg::STATUS_BEHIND
                 || m_data.status == ppdb_pkg::STATUS_OFF
                 || m_data.status == ppdb_pkg::STATUS_CLEARED)
        |-> m_data.cell_column == 7'd0 && m_data.cell_row == 6'd0
         && m_data.glyph_out == 8'd0 && m_data.depth_out == 32'd0)
        else $error("nonzero fields on cell-less result");

    // a drawn point beat a stored depth of at least zero
    a_drawn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ppdb_pkg::STATUS_DRAWN |-> m_data.depth_out != 32'd0)
        else $error("drawn with zero depth");

endmodule

bind point_projection_depth_buffer_top ppdb_assert u_assert (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
`default_nettype wire

/* tb/ppdb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module ppdb_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [1:0]     cfg_wr_index,
    input  wire logic [30:0]    cfg_wr_data,
    input  wire logic           s_valid,
    input  wire logic           s_ready,
    input  wire ppdb_pkg::in_t  s_data,
    input  wire logic           m_valid,
    input  wire logic           m_ready,
    input  wire ppdb_pkg::out_t m_data,
    output int                  fail_count,
    output int                  pending_count,
    output int                  result_count
);
    import ppdb_pkg::*;

    localparam int NCOL = MAX_COLUMNS_DEF;
    localparam int NROW = MAX_ROWS_DEF;

    logic [7:0]  frame_glyph [NCOL*NROW];
    logic [31:0] frame_depth [NCOL*NROW];
    logic [7:0]  width_reg;
    logic [6:0]  height_reg;
    logic [30:0] eye_reg;
    logic [30:0] offset_reg;
    out_t        expected_q [$];

    // signed round-half-away-from-zero of coord * factor / 2^40
    function automatic longint cell_offset(logic signed [31:0] coord, logic [31:0] factor);
        logic [63:0]  mag;
        logic [95:0]  prod;
        logic [63:0]  r;
        mag  = (coord < 0) ? 64'(-longint'(coord)) : 64'(coord);
        prod = 96'(mag) * 96'(factor) + (96'd1 << 39);
        r    = 64'(prod >> 40);
        return (coord < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic out_t plot_point(in_t it);
        out_t        res;
        longint      w, h, den, col, row;
        logic [63:0] q;
        logic [31:0] factor;
        int          idx;
        res = '0;
        w   = (width_reg > NCOL) ? NCOL : width_reg;
        h   = (height_reg > NROW) ? NROW : height_reg;
        den = longint'($signed(it.z_coord)) + longint'(eye_reg) + longint'(offset_reg);
        if (den <= 0) begin
            res.status = STATUS_BEHIND;
            return res;
        end
        q      = (64'(eye_reg) << 24) / 64'(den);
        factor = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        col = w / 2 + cell_offset($signed(it.x_coord), factor);
        row = h / 2 - cell_offset($signed(it.y_coord), factor);
        if (col < 0 || col >= w || row < 0 || row >= h) begin
            res.status = STATUS_OFF;
            return res;
        end
        idx = int'(row) * NCOL + int'(col);
        res.cell_column = col[6:0];
        res.cell_row    = row[5:0];
        if (factor > frame_depth[idx]) begin
            frame_depth[idx] = factor;
            frame_glyph[idx] = it.glyph;
            res.status = STATUS_DRAWN;
        end else begin
            res.status = STATUS_HIDDEN;
        end
        res.glyph_out = frame_glyph[idx];
        res.depth_out = frame_depth[idx];
        return res;
    endfunction

    task automatic wipe_frame();
        for (int i = 0; i < NCOL*NROW; i++) begin
            frame_glyph[i] = GLYPH_SPACE;
            frame_depth[i] = '0;
        end
    endtask

    // model update on configuration writes and input transfers
    always @(posedge aclk) begin
        out_t res;
        res = '0;
        if (!aresetn) begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
            eye_reg    <= EYE_DISTANCE_RST;
            offset_reg <= SCREEN_OFFSET_RST;
            wipe_frame();
            expected_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                case (s_data.func)
                    FUNC_PLOT: expected_q = {expected_q, plot_point(s_data)};
                    FUNC_CLEAR: begin
                        wipe_frame();
                        res.status = STATUS_CLEARED;
                        expected_q = {expected_q, res};
                    end
                    FUNC_READ: begin
                        res.status      = STATUS_READ;
                        res.cell_column = s_data.read_column;
                        res.cell_row    = s_data.read_row;
                        res.glyph_out   = frame_glyph[s_data.read_row*NCOL + s_data.read_column];
                        res.depth_out   = frame_depth[s_data.read_row*NCOL + s_data.read_column];
                        expected_q = {expected_q, res};
                    end
                    default: ;
                endcase
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_SCREEN_WIDTH:  width_reg  <= cfg_wr_data[7:0];
                    CFG_SCREEN_HEIGHT: height_reg <= cfg_wr_data[6:0];
                    CFG_EYE_DISTANCE:  eye_reg    <= cfg_wr_data;
                    CFG_SCREEN_OFFSET: offset_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            fail_count   = 0;
            result_count = 0;
        end else if (m_valid && m_ready) begin
            result_count++;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result %h", $realtime, m_data);
            end else begin
                want = expected_q.pop_front();
                if (m_data !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch st %0d/%0d col %0d/%0d row %0d/%0d g %h/%h d %h/%h",
                                 $realtime, want.status, m_data.status,
                                 want.cell_column, m_data.cell_column,
                                 want.cell_row, m_data.cell_row,
                                 want.glyph_out, m_data.glyph_out,
                                 want.depth_out, m_data.depth_out);
                end
            end
        end
    end

    assign pending_count = expected_q.size();
endmodule
`default_nettype wire

/* tb/tb_point_projection_depth_buffer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_point_projection_depth_buffer_top;
    import ppdb_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_index;
    logic [30:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    int          fail_count;
    int          pending_count;
    int          result_count;
    bit          calm;
    int          plot_count;

    point_projection_depth_buffer_top i_dut (.*);

    ppdb_checker i_checker (.*);

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side stalls at random except in the calm stretch
    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
    end

    // valid stays up after the transfer until the next call drives it
    task automatic send_item(in_t it);
        if (!calm) begin
            while ($urandom_range(99) < 6) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (it.func == FUNC_PLOT) plot_count++;
    endtask

    // the caller drops the write enable after the last write
    task automatic write_reg(logic [1:0] index, logic [30:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        @(posedge aclk);
    endtask

    // wait out every expected result, plus the clear latency
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8400) @(posedge aclk);
    endtask

    function automatic in_t random_bits();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return in_t'(r[$bits(in_t)-1:0]);
    endfunction

    function automatic in_t plot_of(logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, logic [7:0] g);
        in_t it;
        it = random_bits();
        it.func = FUNC_PLOT;
        it.x_coord = x;
        it.y_coord = y;
        it.z_coord = z;
        it.glyph = g;
        return it;
    endfunction

    function automatic in_t read_of(logic [6:0] c, logic [5:0] r);
        in_t it;
        it = random_bits();
        it.func = FUNC_READ;
        it.read_column = c;
        it.read_row = r;
        return it;
    endfunction

    // mostly on-screen points: small x, y scaled to the frame
    function automatic in_t random_item();
        in_t it;
        int  k;
        k = $urandom_range(99);
        it = random_bits();
        if (k < 70) begin
            it.func = FUNC_PLOT;
            it.x_coord = $signed($urandom_range(32'h0050_0000)) - 32'sh0028_0000;
            it.y_coord = $signed($urandom_range(32'h0030_0000)) - 32'sh0018_0000;
            it.z_coord = $signed($urandom_range(32'h0020_0000)) - 32'sh0008_0000;
        end else if (k < 78) begin
            it.func = FUNC_PLOT;
        end else if (k < 95) begin
            it.func = FUNC_READ;
        end else if (k < 97) begin
            it.func = FUNC_CLEAR;
        end else begin
            it.func = FUNC_NONE;
        end
        return it;
    endfunction

    initial begin
        int  limit;
        in_t it;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        calm = 1'b0;
        plot_count = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, depth test, extremes, every function
        send_item(plot_of(0, 0, 0, 8'h41));
        send_item(plot_of(0, 0, 32'sh0001_0000, 8'h42));
        send_item(plot_of(0, 0, -32'sh0001_0000, 8'hFF));
        send_item(plot_of(32'sh0000_8000, -32'sh0000_8000, 0, 8'h00));
        send_item(plot_of(32'sh7FFF_FFFF, 0, 0, 8'h01));
        send_item(plot_of(0, 32'sh8000_0000, 0, 8'h02));
        send_item(plot_of(0, 0, 32'sh8000_0000, 8'h03));
        send_item(plot_of(0, 0, -32'sh0014_0000, 8'h04));
        send_item(plot_of(0, 0, -32'sh0013_FFFF, 8'h05));
        send_item(plot_of(32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh7FFF_FFFF, 8'h06));
        send_item(read_of(7'd40, 6'd20));
        send_item(read_of(7'd127, 6'd63));
        send_item(read_of(7'd0, 6'd0));
        send_item(in_t'({FUNC_CLEAR, 117'h0}));
        send_item(read_of(7'd40, 6'd20));
        it = random_bits();
        it.func = FUNC_NONE;
        send_item(it);
        drain();

        // configuration phases, extremes included
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SCREEN_WIDTH, 31'd128);
                    write_reg(CFG_SCREEN_HEIGHT, 31'd64);
                end
                1: begin
                    write_reg(CFG_SCREEN_WIDTH, 31'd255);
                    write_reg(CFG_SCREEN_HEIGHT, 31'd127);
                    write_reg(CFG_EYE_DISTANCE, 31'h7FFF_FFFF);
                    write_reg(CFG_SCREEN_OFFSET, 31'h7FFF_FFFF);
                end
                2: begin
                    write_reg(CFG_SCREEN_WIDTH, 31'd1);
                    write_reg(CFG_SCREEN_HEIGHT, 31'd1);
                    write_reg(CFG_EYE_DISTANCE, 31'd0);
                    write_reg(CFG_SCREEN_OFFSET, 31'd0);
                end
                3: begin
                    write_reg(CFG_SCREEN_WIDTH, 31'd0);
                    write_reg(CFG_EYE_DISTANCE, 31'h0001_0000);
                end
                4: begin
                    write_reg(CFG_SCREEN_WIDTH, 31'($urandom_range(1, 128)));
                    write_reg(CFG_SCREEN_HEIGHT, 31'($urandom_range(1, 64)));
                    write_reg(CFG_EYE_DISTANCE, 31'($urandom_range(32'h0040_0000)));
                    write_reg(CFG_SCREEN_OFFSET, 31'($urandom_range(32'h0040_0000)));
                end
                default: begin
                    write_reg(CFG_SCREEN_WIDTH, 31'd80);
                    write_reg(CFG_SCREEN_HEIGHT, 31'd40);
                    write_reg(CFG_EYE_DISTANCE, 31'($urandom_range(32'h0020_0000)));
                    write_reg(CFG_SCREEN_OFFSET, 31'($urandom_range(32'h0020_0000)));
                end
            endcase
            cfg_wr_en <= 1'b0;
            calm = (phase == 6);
            limit = (phase < 4) ? 60 : 410;
            for (int n = 0; n < limit; n++) send_item(random_item());
            drain();
        end

        $display("covered %0d results, %0d plots over 8 frame/projection settings",
                 result_count, plot_count);
        if (fail_count == 0)
            $display("point_projection_depth_buffer_top regression: pass");
        else
            $display("point_projection_depth_buffer_top regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #1s;
        $display("point_projection_depth_buffer_top regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
